[rtl/core/ppiah_pkg.sv]
package ppiah_pkg;

    localparam int TRIG_ITER_DEF  = 16;
    localparam int TRIG_TABLE_LEN = 24;
    localparam int ITER_W         = $clog2(TRIG_TABLE_LEN + 1);

    // angles in the trig unit are Q24 radians, heading is Q3.16
    localparam int ANG_W  = 30;
    localparam int TRIG_W = 34;
    localparam int MUL_W  = 36;
    localparam int PROD_W = 2 * MUL_W;
    localparam int NUM_W  = 51;
    localparam int DEN_W  = 26;
    localparam int QUO_W  = 52;

    localparam logic signed [ANG_W-1:0]  PI_Q24      = 30'sd52707179;
    localparam logic signed [ANG_W-1:0]  HALF_PI_Q24 = 30'sd26353589;
    localparam logic signed [ANG_W-1:0]  TWO_PI_Q24  = 30'sd105414357;
    localparam logic signed [TRIG_W-1:0] TRIG_GAIN   = 34'sd652032874;
    localparam logic signed [21:0]       PI_Q16      = 22'sd205887;
    localparam logic signed [21:0]       TWO_PI_Q16  = 22'sd411775;

    localparam logic [1:0] REG_CRUISE = 2'd0;
    localparam logic [1:0] REG_GAIN   = 2'd1;
    localparam logic [1:0] REG_CLIMB  = 2'd2;

    localparam logic [30:0] CRUISE_RST = 31'd327680;
    localparam logic [15:0] GAIN_RST   = 16'd512;
    localparam logic [14:0] CLIMB_RST  = 15'd512;

    function automatic logic signed [ANG_W-1:0] atan_q24(input logic [ITER_W-1:0] idx);
        logic signed [ANG_W-1:0] a;
        begin
            case (idx)
                5'd0:    a = 30'sd13176795;
                5'd1:    a = 30'sd7778716;
                5'd2:    a = 30'sd4110060;
                5'd3:    a = 30'sd2086331;
                5'd4:    a = 30'sd1047214;
                5'd5:    a = 30'sd524117;
                5'd6:    a = 30'sd262123;
                5'd7:    a = 30'sd131069;
                5'd8:    a = 30'sd65536;
                5'd9:    a = 30'sd32768;
                5'd10:   a = 30'sd16384;
                5'd11:   a = 30'sd8192;
                5'd12:   a = 30'sd4096;
                5'd13:   a = 30'sd2048;
                5'd14:   a = 30'sd1024;
                5'd15:   a = 30'sd512;
                5'd16:   a = 30'sd256;
                5'd17:   a = 30'sd128;
                5'd18:   a = 30'sd64;
                5'd19:   a = 30'sd32;
                5'd20:   a = 30'sd16;
                5'd21:   a = 30'sd8;
                5'd22:   a = 30'sd4;
                5'd23:   a = 30'sd2;
                default: a = 30'sd0;
            endcase
            return a;
        end
    endfunction

    // shift right with round to nearest, ties away from zero
    function automatic logic signed [PROD_W-1:0] rnd_sh(input logic signed [PROD_W-1:0] p,
                                                        input int unsigned s);
        logic signed [PROD_W-1:0] h;
        begin
            h = 72'sd1 <<< (s - 1);
            return (p + h - (p[PROD_W-1] ? 72'sd1 : 72'sd0)) >>> s;
        end
    endfunction

endpackage

[rtl/core/ppiah_cordic.sv]
module ppiah_cordic #(
    parameter int TRIG_ITERATIONS = ppiah_pkg::TRIG_ITER_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [ppiah_pkg::ANG_W-1:0]     i_angle,
    output logic                                   o_done,
    output logic signed [ppiah_pkg::TRIG_W-1:0]    o_sin,
    output logic signed [ppiah_pkg::TRIG_W-1:0]    o_cos
);

    localparam int N = (TRIG_ITERATIONS > ppiah_pkg::TRIG_TABLE_LEN) ?
                       ppiah_pkg::TRIG_TABLE_LEN : TRIG_ITERATIONS;
    localparam logic [ppiah_pkg::ITER_W-1:0] LAST = ppiah_pkg::ITER_W'(N - 1);

    typedef enum logic [1:0] {C_IDLE, C_RED, C_ITER} t_cstate;

    t_cstate                              r_state;
    logic                                 r_done;
    logic                                 r_flip;
    logic [ppiah_pkg::ITER_W-1:0]         r_cnt;
    logic signed [ppiah_pkg::ANG_W-1:0]   r_ang;
    logic signed [ppiah_pkg::TRIG_W-1:0]  r_x;
    logic signed [ppiah_pkg::TRIG_W-1:0]  r_y;
    logic signed [ppiah_pkg::TRIG_W-1:0]  xs;
    logic signed [ppiah_pkg::TRIG_W-1:0]  ys;

    assign xs = r_x >>> r_cnt;
    assign ys = r_y >>> r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_ang   <= i_angle;
                        r_state <= C_RED;
                    end
                end
                C_RED: begin
                    // one 2*pi step per cycle, then fold into the right half plane
                    if (r_ang > ppiah_pkg::PI_Q24) begin
                        r_ang <= r_ang - ppiah_pkg::TWO_PI_Q24;
                    end else if (r_ang < -ppiah_pkg::PI_Q24) begin
                        r_ang <= r_ang + ppiah_pkg::TWO_PI_Q24;
                    end else begin
                        if (r_ang > ppiah_pkg::HALF_PI_Q24) begin
                            r_ang  <= r_ang - ppiah_pkg::PI_Q24;
                            r_flip <= 1'b1;
                        end else if (r_ang < -ppiah_pkg::HALF_PI_Q24) begin
                            r_ang  <= r_ang + ppiah_pkg::PI_Q24;
                            r_flip <= 1'b1;
                        end else begin
                            r_flip <= 1'b0;
                        end
                        r_x     <= ppiah_pkg::TRIG_GAIN;
                        r_y     <= '0;
                        r_cnt   <= '0;
                        r_state <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (r_ang >= 0) begin
                        r_x   <= r_x - ys;
                        r_y   <= r_y + xs;
                        r_ang <= r_ang - ppiah_pkg::atan_q24(r_cnt);
                    end else begin
                        r_x   <= r_x + ys;
                        r_y   <= r_y - xs;
                        r_ang <= r_ang + ppiah_pkg::atan_q24(r_cnt);
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_flip ? -r_y : r_y;
    assign o_cos  = r_flip ? -r_x : r_x;

endmodule

[rtl/core/ppiah_div.sv]
module ppiah_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [ppiah_pkg::NUM_W-1:0]    i_num,
    input  logic signed [ppiah_pkg::DEN_W-1:0]    i_den,
    output logic                                  o_done,
    output logic signed [ppiah_pkg::QUO_W-1:0]    o_quot
);

    localparam int NW = ppiah_pkg::NUM_W;
    localparam int DW = ppiah_pkg::DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [CW-1:0]     r_cnt;
    logic [NW-1:0]     r_q;
    logic [DW:0]       r_rem;
    logic [DW-1:0]     r_md;
    logic [NW-1:0]     mn;
    logic [DW-1:0]     md;
    logic [DW+1:0]     rem_sh;
    logic [DW+1:0]     rem_sub;

    assign mn      = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
    assign md      = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
    assign rem_sh  = {r_rem, r_q[NW-1]};
    assign rem_sub = rem_sh - {2'b00, r_md};

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_neg  <= i_num[NW-1] ^ i_den[DW-1];
                r_md   <= md;
                r_q    <= mn + NW'(md >> 1);
                r_rem  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (!rem_sub[DW+1]) begin
                    r_rem <= rem_sub[DW:0];
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[DW:0];
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

endmodule

[rtl/core/planar_pose_integrator_altitude_hold.sv]
// Each item runs the shared CORDIC (load, reduction steps and TRIG_ITERATIONS rotations) twice
// on a straight step and three times on an arc step, and the bit-serial divider (load plus one
// pass per quotient bit) twice on an arc step; a stalled earlier result holds the step at its end.
// Throughput: one item at a time; the next item is taken the cycle after the result is registered.
// Reset: synchronous, active low; pose, altitude target and handshakes clear, config to defaults.
module planar_pose_integrator_altitude_hold #(
    parameter int TRIG_ITERATIONS = ppiah_pkg::TRIG_ITER_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [47:0]  i_s_tdata,  // linear_speed, turn_rate, time_step
    input  logic         i_s_tuser,  // climb_request
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // pos_x, pos_y, pos_z, heading, climb_rate, quat_z, quat_w, zero fill
    output logic [167:0] o_m_tdata,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [3:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output logic [31:0]  o_prdata,
    output logic         o_pready
);

    localparam int MW = ppiah_pkg::MUL_W;
    localparam int PW = ppiah_pkg::PROD_W;
    localparam int TW = ppiah_pkg::TRIG_W;

    typedef enum logic [4:0] {
        S_IDLE, S_TRIG0, S_TRIG0_W, S_MW, S_DIST, S_SDX, S_SDY, S_SDONE,
        S_WDT, S_END, S_TRIG1_W, S_DIVX, S_DIVX_W, S_DIVY, S_DIVY_W,
        S_POSE, S_VZ, S_Z, S_QUAT_W, S_OUT
    } t_state;

    t_state                  r_state;
    t_state                  r_ret;
    logic [30:0]             r_cruise;
    logic [15:0]             r_gain;
    logic [14:0]             r_lim;
    logic signed [31:0]      r_px;
    logic signed [31:0]      r_py;
    logic [30:0]             r_pz;
    logic signed [19:0]      r_yaw;
    logic [30:0]             r_target;
    logic signed [15:0]      r_v;
    logic signed [15:0]      r_w;
    logic [15:0]             r_dt;
    logic signed [21:0]      r_end;
    logic signed [TW-1:0]    r_s0;
    logic signed [TW-1:0]    r_c0;
    logic signed [TW-1:0]    r_c1;
    logic signed [51:0]      r_dx;
    logic signed [51:0]      r_dy;
    logic signed [15:0]      r_vz;
    logic signed [15:0]      r_qs;
    logic signed [15:0]      r_qc;
    logic signed [MW-1:0]    r_ma;
    logic signed [MW-1:0]    r_mb;
    logic signed [PW-1:0]    r_prod;
    logic                    r_cstart;
    logic signed [ppiah_pkg::ANG_W-1:0] r_cang;
    logic                    r_dstart;
    logic                    r_mv;
    logic [161:0]            r_out;

    logic                    c_done;
    logic signed [TW-1:0]    c_sin;
    logic signed [TW-1:0]    c_cos;
    logic                    d_done;
    logic signed [ppiah_pkg::QUO_W-1:0] d_quot;

    logic                    s_acc;
    logic                    cfg_wr;
    logic signed [21:0]      end_c;
    logic signed [21:0]      wr1;
    logic signed [21:0]      wr2;
    logic signed [21:0]      wr3;
    logic signed [21:0]      wr4;
    logic signed [52:0]      sx;
    logic signed [52:0]      sy;
    logic signed [31:0]      nx;
    logic signed [31:0]      ny;
    logic signed [PW-1:0]    rv;
    logic signed [PW-1:0]    rlim;
    logic signed [15:0]      vz_c;
    logic signed [33:0]      zs;
    logic [30:0]             nz;
    logic signed [PW-1:0]    rqs;
    logic signed [PW-1:0]    rqc;
    logic signed [32:0]      err;

    ppiah_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cstart),
        .i_angle (r_cang),
        .o_done  (c_done),
        .o_sin   (c_sin),
        .o_cos   (c_cos)
    );

    ppiah_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_prod[ppiah_pkg::NUM_W-1:0]),
        .i_den   ({r_w, 10'b0}),
        .o_done  (d_done),
        .o_quot  (d_quot)
    );

    // shared multiplier
    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
    end

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_pready   = 1'b1;
    assign cfg_wr     = i_psel && i_penable && i_pwrite;

    always_comb begin
        case (i_paddr[3:2])
            ppiah_pkg::REG_CRUISE: o_prdata = {1'b0, r_cruise};
            ppiah_pkg::REG_GAIN:   o_prdata = {16'b0, r_gain};
            ppiah_pkg::REG_CLIMB:  o_prdata = {17'b0, r_lim};
            default:               o_prdata = '0;
        endcase
    end

    assign end_c = 22'(ppiah_pkg::rnd_sh(r_prod, 12)) + 22'(r_yaw);

    // heading wrap, applied twice
    assign wr1 = (r_end > ppiah_pkg::PI_Q16) ? r_end - ppiah_pkg::TWO_PI_Q16 : r_end;
    assign wr2 = (wr1 < -ppiah_pkg::PI_Q16) ? wr1 + ppiah_pkg::TWO_PI_Q16 : wr1;
    assign wr3 = (wr2 > ppiah_pkg::PI_Q16) ? wr2 - ppiah_pkg::TWO_PI_Q16 : wr2;
    assign wr4 = (wr3 < -ppiah_pkg::PI_Q16) ? wr3 + ppiah_pkg::TWO_PI_Q16 : wr3;

    assign sx = 53'(r_px) + 53'(r_dx);
    assign sy = 53'(r_py) + 53'(r_dy);
    assign nx = (sx > 53'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                (sx < -53'sh80000000) ? -32'sh80000000 : 32'(sx);
    assign ny = (sy > 53'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                (sy < -53'sh80000000) ? -32'sh80000000 : 32'(sy);

    assign err  = $signed({2'b00, r_target}) - $signed({2'b00, r_pz});
    assign rv   = ppiah_pkg::rnd_sh(r_prod, 16);
    assign rlim = $signed({57'b0, r_lim});
    assign vz_c = (rv > rlim) ? $signed({1'b0, r_lim}) :
                  (rv < -rlim) ? -$signed({1'b0, r_lim}) : 16'(rv);

    assign zs = $signed({3'b000, r_pz}) + 34'(ppiah_pkg::rnd_sh(r_prod, 8));
    assign nz = (zs < 0) ? 31'd0 : (zs > 34'sh7FFFFFFF) ? 31'h7FFFFFFF : 31'(zs);

    assign rqs = ppiah_pkg::rnd_sh(PW'(c_sin), 15);
    assign rqc = ppiah_pkg::rnd_sh(PW'(c_cos), 15);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_cruise <= ppiah_pkg::CRUISE_RST;
            r_gain   <= ppiah_pkg::GAIN_RST;
            r_lim    <= ppiah_pkg::CLIMB_RST;
            r_px     <= '0;
            r_py     <= '0;
            r_pz     <= '0;
            r_yaw    <= '0;
            r_target <= '0;
            r_cstart <= 1'b0;
            r_dstart <= 1'b0;
            r_mv     <= 1'b0;
        end else begin
            r_cstart <= 1'b0;
            r_dstart <= 1'b0;
            if (r_mv && i_m_tready && r_state != S_OUT) begin
                r_mv <= 1'b0;
            end
            if (cfg_wr) begin
                case (i_paddr[3:2])
                    ppiah_pkg::REG_CRUISE: r_cruise <= i_pwdata[30:0];
                    ppiah_pkg::REG_GAIN:   r_gain   <= i_pwdata[15:0];
                    ppiah_pkg::REG_CLIMB:  r_lim    <= i_pwdata[14:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_v     <= $signed(i_s_tdata[15:0]);
                        r_w     <= $signed(i_s_tdata[31:16]);
                        r_dt    <= i_s_tdata[47:32];
                        if (i_s_tuser) begin
                            r_target <= r_cruise;
                        end
                        r_state <= S_TRIG0;
                    end
                end
                S_TRIG0: begin
                    r_cstart <= 1'b1;
                    r_cang   <= 30'(r_yaw) <<< 8;
                    r_state  <= S_TRIG0_W;
                end
                S_TRIG0_W: begin
                    if (c_done) begin
                        r_s0  <= c_sin;
                        r_c0  <= c_cos;
                        r_end <= 22'(r_yaw);
                        r_state <= (r_w == 16'sd0) ? S_DIST : S_WDT;
                    end
                end
                S_MW: r_state <= r_ret;
                // straight step
                S_DIST: begin
                    r_ma    <= MW'(r_v);
                    r_mb    <= $signed({20'b0, r_dt});
                    r_ret   <= S_SDX;
                    r_state <= S_MW;
                end
                S_SDX: begin
                    r_ma    <= MW'($signed(r_prod[32:0]));
                    r_mb    <= MW'(r_c0);
                    r_ret   <= S_SDY;
                    r_state <= S_MW;
                end
                S_SDY: begin
                    r_dx    <= 52'(ppiah_pkg::rnd_sh(r_prod, 38));
                    r_mb    <= MW'(r_s0);
                    r_ret   <= S_SDONE;
                    r_state <= S_MW;
                end
                S_SDONE: begin
                    r_dy    <= 52'(ppiah_pkg::rnd_sh(r_prod, 38));
                    r_state <= S_POSE;
                end
                // arc step
                S_WDT: begin
                    r_ma    <= MW'(r_w);
                    r_mb    <= $signed({20'b0, r_dt});
                    r_ret   <= S_END;
                    r_state <= S_MW;
                end
                S_END: begin
                    r_end    <= end_c;
                    r_cstart <= 1'b1;
                    r_cang   <= 30'(end_c) <<< 8;
                    r_state  <= S_TRIG1_W;
                end
                S_TRIG1_W: begin
                    if (c_done) begin
                        r_c1    <= c_cos;
                        r_ma    <= MW'(r_v);
                        r_mb    <= MW'(c_sin) - MW'(r_s0);
                        r_ret   <= S_DIVX;
                        r_state <= S_MW;
                    end
                end
                S_DIVX: begin
                    r_dstart <= 1'b1;
                    r_state  <= S_DIVX_W;
                end
                S_DIVX_W: begin
                    if (d_done) begin
                        r_dx    <= d_quot;
                        r_mb    <= MW'(r_c0) - MW'(r_c1);
                        r_ret   <= S_DIVY;
                        r_state <= S_MW;
                    end
                end
                S_DIVY: begin
                    r_dstart <= 1'b1;
                    r_state  <= S_DIVY_W;
                end
                S_DIVY_W: begin
                    if (d_done) begin
                        r_dy    <= d_quot;
                        r_state <= S_POSE;
                    end
                end
                // pose, then altitude hold, then heading quaternion and output
                S_POSE: begin
                    r_px    <= nx;
                    r_py    <= ny;
                    r_yaw   <= 20'(wr4);
                    r_ma    <= $signed({20'b0, r_gain});
                    r_mb    <= MW'(err);
                    r_ret   <= S_VZ;
                    r_state <= S_MW;
                end
                S_VZ: begin
                    r_vz    <= vz_c;
                    r_ma    <= MW'(vz_c);
                    r_mb    <= $signed({20'b0, r_dt});
                    r_ret   <= S_Z;
                    r_state <= S_MW;
                end
                S_Z: begin
                    r_pz     <= nz;
                    r_cstart <= 1'b1;
                    r_cang   <= 30'(r_yaw) <<< 7;
                    r_state  <= S_QUAT_W;
                end
                S_QUAT_W: begin
                    if (c_done) begin
                        r_qs <= (rqs > 72'sd32767) ? 16'sh7FFF :
                                (rqs < -72'sd32768) ? -16'sh8000 : 16'(rqs);
                        r_qc <= (rqc > 72'sd32767) ? 16'sh7FFF :
                                (rqc < -72'sd32768) ? -16'sh8000 : 16'(rqc);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_mv || i_m_tready) begin
                        r_out   <= {r_qc, r_qs, r_vz, r_yaw[18:0], r_pz, r_py, r_px};
                        r_mv    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_mv;
    assign o_m_tdata  = {6'b0, r_out};

endmodule

[rtl/core/ppiah_checker.sv]
module ppiah_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [167:0] o_m_tdata
);

    // one item in flight: input closes right after an accept
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input still open after accept");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[113:95]) <= 19'sd205887 &&
                        $signed(o_m_tdata[113:95]) >= -19'sd205887))
        else $error("heading outside wrap range");

    a_climb_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[129:114] != 16'h8000))
        else $error("climb rate beyond limit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result dropped while stalled");

endmodule

bind planar_pose_integrator_altitude_hold ppiah_checker u_ppiah_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

[tb/tb.sv]
module tb;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     SETTLE      = 250;
    localparam int     CORDIC_ITER = 16;

    localparam longint PI16   = 205887;
    localparam longint TWOPI16 = 411775;
    localparam longint PI24   = 52707179;
    localparam longint HPI24  = 26353589;
    localparam longint TWOPI24 = 105414357;
    localparam longint CGAIN  = 652032874;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [30:0]        z;
        logic signed [18:0] hdg;
        logic signed [15:0] vz;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } t_pose;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [47:0]  i_s_tdata;   // linear_speed, turn_rate, time_step
    logic         i_s_tuser;   // climb_request
    logic         o_m_tvalid;
    logic         i_m_tready;
    // pos_x, pos_y, pos_z, heading, climb_rate, quat_z, quat_w, zero fill
    logic [167:0] o_m_tdata;
    logic         i_psel;
    logic         i_penable;
    logic         i_pwrite;
    logic [3:0]   i_paddr;
    logic [31:0]  i_pwdata;
    logic [31:0]  o_prdata;
    logic         o_pready;

    planar_pose_integrator_altitude_hold i_dut (.*);

    // predictor copy of the block state
    longint cruise_alt, alt_gain, climb_lim;
    longint px, py, pz, yaw, alt_tgt;

    t_pose  pose_q[$];
    int     n_err;
    int     tx_idle_pct;
    int     rx_idle_pct;
    longint cycles;

    longint atan_lut[24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint round_shift(input longint v, input int s);
        longint unsigned mag;
        longint r;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        r = longint'((mag + (64'd1 << (s - 1))) >> s);
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint round_div(input longint n, input longint d);
        longint unsigned mn, md;
        longint q;
        mn = (n < 0) ? -n : n;
        md = (d < 0) ? -d : d;
        q = longint'((mn + md / 2) / md);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // rotation-mode CORDIC, Q24 angle in, Q2.30 sine/cosine out
    function automatic void sin_cos(input longint a, output longint s, output longint c);
        longint x, y, xs, ys;
        bit     flip;
        x = CGAIN;
        y = 0;
        flip = 1'b0;
        while (a > PI24) a -= TWOPI24;
        while (a < -PI24) a += TWOPI24;
        if (a > HPI24) begin
            a -= PI24;
            flip = 1'b1;
        end else if (a < -HPI24) begin
            a += PI24;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_ITER; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (a >= 0) begin
                x -= ys;
                y += xs;
                a -= atan_lut[i];
            end else begin
                x += ys;
                y -= xs;
                a += atan_lut[i];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic t_pose integrate_tick(input longint v, input longint w, input longint dt,
                                             input bit climb);
        longint dx, dy, s0, c0, s1, c1, hd, vz, qs, qc;
        t_pose  r;
        hd = yaw;
        if (climb) alt_tgt = cruise_alt;
        sin_cos(hd * 256, s0, c0);
        if (w == 0) begin
            dx = round_shift(v * dt * c0, 38);
            dy = round_shift(v * dt * s0, 38);
        end else begin
            hd = hd + round_shift(w * dt, 12);
            sin_cos(hd * 256, s1, c1);
            dx = round_div(v * (s1 - s0), w * 1024);
            dy = round_div(v * (c0 - c1), w * 1024);
        end
        px = clip(px + dx, -64'sd2147483648, 64'sd2147483647);
        py = clip(py + dy, -64'sd2147483648, 64'sd2147483647);
        // second pass only matters on a very large turn
        for (int k = 0; k < 2; k++) begin
            if (hd > PI16) hd -= TWOPI16;
            if (hd < -PI16) hd += TWOPI16;
        end
        yaw = hd;
        vz = clip(round_shift(alt_gain * (alt_tgt - pz), 16), -climb_lim, climb_lim);
        pz = clip(pz + round_shift(vz * dt, 8), 0, 64'sd2147483647);
        sin_cos(hd * 128, qs, qc);
        qs = clip(round_shift(qs, 15), -32768, 32767);
        qc = clip(round_shift(qc, 15), -32768, 32767);
        r.x = px[31:0];
        r.y = py[31:0];
        r.z = pz[30:0];
        r.hdg = hd[18:0];
        r.vz = vz[15:0];
        r.qz = qs[15:0];
        r.qw = qc[15:0];
        return r;
    endfunction

    task automatic send_tick(input logic signed [15:0] v, input logic signed [15:0] w,
                             input logic [15:0] dt, input bit climb);
        int gap;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {dt, w, v};
        i_s_tuser <= climb;
        do @(posedge i_clk); while (!o_s_tready);
        pose_q.push_back(integrate_tick(v, w, dt, climb));
    endtask

    task automatic drain;
        i_s_tvalid <= 1'b0;
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= {idx, 2'b00};
        i_pwdata <= data;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        case (idx)
            ppiah_pkg::REG_CRUISE: cruise_alt = data[30:0];
            ppiah_pkg::REG_GAIN:   alt_gain = data[15:0];
            ppiah_pkg::REG_CLIMB:  climb_lim = data[14:0];
            default: ;  // unmapped index, ignored
        endcase
    endtask

    task automatic set_regs(input logic [31:0] cr, input logic [31:0] g, input logic [31:0] m);
        reg_write(ppiah_pkg::REG_CRUISE, cr);
        reg_write(ppiah_pkg::REG_GAIN, g);
        reg_write(ppiah_pkg::REG_CLIMB, m);
    endtask

    task automatic test_directed;
        send_tick(16'sd256, 16'sd0, 16'd32768, 1'b0);     // heading zero: quat_w saturates
        send_tick(16'sd32767, 16'sd0, 16'd65535, 1'b1);
        send_tick(-16'sd32768, 16'sd0, 16'd65535, 1'b0);
        send_tick(16'sd1000, 16'sd4096, 16'd0, 1'b0);
        send_tick(16'sd32767, 16'sd32767, 16'd65535, 1'b0); // double wrap
        send_tick(-16'sd32768, -16'sd32768, 16'd65535, 1'b1);
        send_tick(16'sd500, 16'sd1, 16'd1, 1'b0);
        send_tick(16'sd500, -16'sd1, 16'd65535, 1'b0);
        send_tick(16'sd0, 16'sd6434, 16'd65535, 1'b0);
        send_tick(-16'sd1, 16'sd12868, 16'd40000, 1'b0);
        send_tick(16'sd300, 16'sd0, 16'd0, 1'b1);
        send_tick(16'sd32767, -16'sd32768, 16'd1, 1'b0);
        drain();
        reg_write(2'd3, 32'hFFFF_FFFF);
        send_tick(16'sd100, 16'sd100, 16'd1000, 1'b0);
        drain();
    endtask

    // drive position and altitude into their limits, then back down to the floor
    task automatic test_limits;
        set_regs(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_7FFF);
        for (int i = 0; i < 300; i++) send_tick(16'sd32767, 16'sd0, 16'd65535, i == 0);
        drain();
        set_regs(32'd0, 32'h0000_FFFF, 32'h0000_7FFF);
        for (int i = 0; i < 560; i++) send_tick(-16'sd32768, 16'sd0, 16'd65535, i == 0);
        drain();
    endtask

    task automatic test_random(input int n);
        logic signed [15:0] v, w;
        logic [15:0]        dt;
        for (int i = 0; i < n; i++) begin
            v = ($urandom_range(3) == 0) ? 16'($urandom_range(2047)) - 16'sd1024
                                          : 16'($urandom);
            case ($urandom_range(4))
                0:       w = 16'sd0;
                1:       w = 16'($urandom_range(511)) - 16'sd256;
                default: w = 16'($urandom);
            endcase
            dt = ($urandom_range(1) == 0) ? 16'($urandom_range(4095)) : 16'($urandom);
            send_tick(v, w, dt, $urandom_range(9) == 0);
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        t_pose got, want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.x = o_m_tdata[31:0];
            got.y = o_m_tdata[63:32];
            got.z = o_m_tdata[94:64];
            got.hdg = o_m_tdata[113:95];
            got.vz = o_m_tdata[129:114];
            got.qz = o_m_tdata[145:130];
            got.qw = o_m_tdata[161:146];
            if (pose_q.size() == 0) begin
                n_err++;
                $display("%0t: unexpected item %h", $time, o_m_tdata);
            end else begin
                want = pose_q.pop_front();
                if (got.x !== want.x)
                    $display("%0t: pos_x exp %0d got %0d", $time, want.x, got.x);
                if (got.y !== want.y)
                    $display("%0t: pos_y exp %0d got %0d", $time, want.y, got.y);
                if (got.z !== want.z)
                    $display("%0t: pos_z exp %0d got %0d", $time, want.z, got.z);
                if (got.hdg !== want.hdg)
                    $display("%0t: heading exp %0d got %0d", $time, want.hdg, got.hdg);
                if (got.vz !== want.vz)
                    $display("%0t: climb_rate exp %0d got %0d", $time, want.vz, got.vz);
                if (got.qz !== want.qz)
                    $display("%0t: quat_z exp %0d got %0d", $time, want.qz, got.qz);
                if (got.qw !== want.qw)
                    $display("%0t: quat_w exp %0d got %0d", $time, want.qw, got.qw);
                if (got !== want) n_err++;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_m_tready = 1'b0;
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
        i_paddr = '0;
        i_pwdata = '0;
        cycles = 0;
        n_err = 0;
        cruise_alt = 327680;
        alt_gain = 512;
        climb_lim = 512;
        px = 0; py = 0; pz = 0; yaw = 0; alt_tgt = 0;
        tx_idle_pct = 33;
        rx_idle_pct = 75;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_limits();
        set_regs(32'd655360, 32'd256, 32'd2048);
        test_random(130);

        tx_idle_pct = 75;
        rx_idle_pct = 33;
        set_regs(32'd3276800, 32'd65535, 32'd0);
        test_random(40);
        set_regs(32'd0, 32'd0, 32'd32767);
        test_random(40);
        set_regs(32'h7FFF_FFFF, 32'd4096, 32'd32767);
        test_random(40);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_regs(32'd1, 32'd1, 32'd1);
        test_random(60);
        set_regs(32'd196608, 32'd512, 32'd512);
        test_random(70);

        if (n_err == 0 && pose_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
